// ----- rtl/core/afgp_pkg.sv -----
// ----------------------------------------------------------------------------
// afgp_pkg
// Shared constants, register codes and the divider request for the fade,
// gain and peak block.
// ----------------------------------------------------------------------------
package afgp_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int GAIN_BITS     = 16;
  localparam int FRAME_BITS    = 32;
  localparam int CHAN_CFG_BITS = 4;

  localparam int ENV_FRAC    = 16;
  localparam int ENV_BITS    = ENV_FRAC + 1;
  localparam int DIV_STEPS   = ENV_BITS;
  localparam int ROUND_SHIFT = 28;

  localparam logic [ENV_BITS-1:0]      ENV_ONE     = ENV_BITS'(1) << ENV_FRAC;
  localparam logic [GAIN_BITS-1:0]     GAIN_RESET  = GAIN_BITS'(4096);
  localparam logic [FRAME_BITS-1:0]    TAKE_RESET  = FRAME_BITS'(1);
  localparam logic [CHAN_CFG_BITS-1:0] CHAN_RESET  = CHAN_CFG_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_TAKE_FRAMES = 3'd1,
    CFG_FADE_IN     = 3'd2,
    CFG_FADE_OUT    = 3'd3,
    CFG_CHANNELS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                  start;
    logic [FRAME_BITS-1:0] num;
    logic [FRAME_BITS-1:0] den;
  } div_req_t;

endpackage

// ----- rtl/core/afgp_if.sv -----
// ----------------------------------------------------------------------------
// afgp channel interfaces
// Sample input, result output and register write channels, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
interface afgp_in_if #(
  parameter int SAMPLE_BITS = afgp_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface afgp_out_if #(
  parameter int SAMPLE_BITS = afgp_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [SAMPLE_BITS+3:0]        peak_level;
  logic                          clipped;
  logic                          take_end;

  modport source (output valid, output sample_out, output peak_level, output clipped,
                  output take_end, input ready);
  modport sink   (input valid, input sample_out, input peak_level, input clipped,
                  input take_end, output ready);
endinterface

interface afgp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [afgp_pkg::CFG_IDX_BITS-1:0]    index;
  logic [afgp_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/afgp_div.sv -----
// ----------------------------------------------------------------------------
// afgp_div
// Restoring divider for the ramp value: floor(num * 2^16 / den), one
// quotient bit per cycle, 17 bits, quotient known to stay below 2^17.
// ----------------------------------------------------------------------------
module afgp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  afgp_pkg::div_req_t                req,
  output logic                              done,
  output logic [afgp_pkg::ENV_BITS-1:0]     quo
);

  localparam int FW    = afgp_pkg::FRAME_BITS;
  localparam int CNT_W = $clog2(afgp_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(afgp_pkg::DIV_STEPS - 1);

  logic                            busy_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [FW:0]                     rem_r;
  logic [FW-1:0]                   den_r;
  logic                            lsb_r;
  logic [afgp_pkg::ENV_BITS-2:0]   q_r;

  logic [FW:0] shifted;
  logic [FW:0] diff;
  logic        ge;
  logic        last;

  always_comb begin
    shifted = {rem_r[FW-1:0], (cnt_r == CNT_TOP) ? lsb_r : 1'b0};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    last    = cnt_r == '0;
  end

  assign done = busy_r & last;
  assign quo  = {q_r, ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_TOP;
        rem_r  <= {2'b00, req.num[FW-1:1]};
        lsb_r  <= req.num[0];
        den_r  <= req.den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff : shifted;
        q_r   <= {q_r[afgp_pkg::ENV_BITS-3:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/core/afgp_mul.sv -----
// ----------------------------------------------------------------------------
// afgp_mul
// Shared unsigned multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module afgp_mul #(
  parameter int A_W = afgp_pkg::SAMPLE_BITS_DEF + afgp_pkg::GAIN_BITS,
  parameter int B_W = afgp_pkg::ENV_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/audio_fade_gain_peak.sv -----
// ----------------------------------------------------------------------------
// audio_fade_gain_peak
// The next input is accepted only once the previous result has been loaded
// into the output register; each active ramp costs one run of the shared
// divider, and the gain and envelope products take three passes through the
// shared multiplier.
// Reset: synchronous; registers return to unity gain, one-frame take, no
//   fades, two channels; position, peak and clip flag clear.
// ----------------------------------------------------------------------------
module audio_fade_gain_peak #(
  parameter int SAMPLE_BITS  = afgp_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = afgp_pkg::MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  afgp_in_if.sink    in_ch,
  afgp_out_if.source out_ch,
  afgp_cfg_if.sink   cfg_ch
);

  localparam int FW    = afgp_pkg::FRAME_BITS;
  localparam int EW    = afgp_pkg::ENV_BITS;
  localparam int GW    = afgp_pkg::GAIN_BITS;
  localparam int CCW   = afgp_pkg::CHAN_CFG_BITS;
  localparam int A_W   = SAMPLE_BITS + GW;
  localparam int P_W   = A_W + EW;
  localparam int M_W   = SAMPLE_BITS + 4;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > CCW) ? $clog2(MAX_CHANNELS + 1) : CCW;

  localparam logic [M_W-1:0]   FULL_M     = M_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [P_W-1:0]   ROUND_HALF = P_W'(1) << (afgp_pkg::ROUND_SHIFT - 1);
  localparam logic [CNT_W-1:0] MAX_CH     = CNT_W'(MAX_CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE, S_FI, S_FI_W, S_FO, S_FO_W, S_ENV, S_MG, S_PE, S_FIN
  } state_t;

  // configuration
  logic [GW-1:0]  gain_r;
  logic [FW-1:0]  take_r;
  logic [FW-1:0]  fade_in_r;
  logic [FW-1:0]  fade_out_r;
  logic [CCW-1:0] chan_cnt_r;

  // sequencer and take state
  state_t                 state_r, state_nxt;
  logic [FW-1:0]          pos_r, pos_nxt;
  logic [CH_W-1:0]        chan_r, chan_nxt;
  logic [M_W-1:0]         peak_r, peak_nxt;
  logic                   clip_r, clip_nxt;

  // datapath
  logic                   neg_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [EW-1:0]          fi_r;
  logic [EW-1:0]          fo_r;
  logic [EW-1:0]          env_r;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [M_W-1:0]                out_peak_r;
  logic                          out_clip_r;
  logic                          out_end_r;

  logic                   in_xfer;
  logic                   out_free;
  logic [FW-1:0]          frames;
  logic [CNT_W-1:0]       chans;
  logic                   fi_act;
  logic                   fo_act;
  logic [FW-1:0]          fo_num;
  afgp_pkg::div_req_t     div_req;
  logic                   div_done;
  logic [EW-1:0]          div_quo;
  logic                   mul_en;
  logic [A_W-1:0]         mul_a;
  logic [EW-1:0]          mul_b;
  logic [P_W-1:0]         mul_p;
  logic [P_W-1:0]         round_sum;
  logic [M_W-1:0]         m;
  logic [M_W-1:0]         sat;
  logic [SAMPLE_BITS-1:0] sat_b;
  logic [SAMPLE_BITS-1:0] sample_res;
  logic                   last_chan;
  logic                   last_frame;
  logic                   take_end;
  logic [SAMPLE_BITS-1:0] in_raw;

  assign in_ch.ready  = state_r == S_IDLE;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_raw       = in_ch.sample_in;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.peak_level = out_peak_r;
  assign out_ch.clipped    = out_clip_r;
  assign out_ch.take_end   = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= afgp_pkg::GAIN_RESET;
      take_r     <= afgp_pkg::TAKE_RESET;
      fade_in_r  <= '0;
      fade_out_r <= '0;
      chan_cnt_r <= afgp_pkg::CHAN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        afgp_pkg::CFG_GAIN:        gain_r     <= cfg_ch.data[GW-1:0];
        afgp_pkg::CFG_TAKE_FRAMES: take_r     <= cfg_ch.data[FW-1:0];
        afgp_pkg::CFG_FADE_IN:     fade_in_r  <= cfg_ch.data[FW-1:0];
        afgp_pkg::CFG_FADE_OUT:    fade_out_r <= cfg_ch.data[FW-1:0];
        afgp_pkg::CFG_CHANNELS:    chan_cnt_r <= cfg_ch.data[CCW-1:0];
        default: ;
      endcase
    end
  end

  // ramp conditions and divider request
  always_comb begin
    frames = (take_r == '0) ? FW'(1) : take_r;
    if (chan_cnt_r == '0) begin
      chans = CNT_W'(1);
    end else if (CNT_W'(chan_cnt_r) > MAX_CH) begin
      chans = MAX_CH;
    end else begin
      chans = CNT_W'(chan_cnt_r);
    end
    fi_act = (fade_in_r != '0) && (pos_r < fade_in_r);
    fo_act = (fade_out_r != '0) &&
             (({1'b0, pos_r} + {1'b0, fade_out_r}) >= {1'b0, frames});
    fo_num = (pos_r < frames) ? (frames - pos_r) : '0;
    div_req.start = ((state_r == S_FI) && fi_act) || ((state_r == S_FO) && fo_act);
    div_req.num   = (state_r == S_FI) ? pos_r : fo_num;
    div_req.den   = (state_r == S_FI) ? fade_in_r : fade_out_r;
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_ENV: begin
        mul_en = 1'b1;
        mul_a  = A_W'(fi_r);
        mul_b  = fo_r;
      end
      S_MG: begin
        mul_en = 1'b1;
        mul_a  = A_W'(mag_r);
        mul_b  = EW'(gain_r);
      end
      S_PE: begin
        mul_en = 1'b1;
        mul_a  = mul_p[A_W-1:0];
        mul_b  = env_r;
      end
      default: ;
    endcase
  end

  // round, saturate, meter and advance position
  always_comb begin
    round_sum  = mul_p + ROUND_HALF;
    m          = round_sum[afgp_pkg::ROUND_SHIFT +: M_W];
    if (neg_r) begin
      sat = (m >= FULL_M) ? FULL_M : m;
    end else begin
      sat = (m >= FULL_M) ? (FULL_M - 1'b1) : m;
    end
    sat_b      = sat[SAMPLE_BITS-1:0];
    sample_res = neg_r ? (~sat_b + 1'b1) : sat_b;
    peak_nxt   = (m > peak_r) ? m : peak_r;
    clip_nxt   = clip_r | (m > FULL_M);
    last_chan  = (CNT_W'(chan_r) + 1'b1) >= chans;
    last_frame = ({1'b0, pos_r} + 1'b1) >= {1'b0, frames};
    take_end   = last_chan && last_frame;
    if (take_end) begin
      pos_nxt  = '0;
      chan_nxt = '0;
    end else if (last_chan) begin
      pos_nxt  = pos_r + 1'b1;
      chan_nxt = '0;
    end else begin
      pos_nxt  = pos_r;
      chan_nxt = chan_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_FI;
      S_FI:    state_nxt = fi_act ? S_FI_W : S_FO;
      S_FI_W:  if (div_done) state_nxt = S_FO;
      S_FO:    state_nxt = fo_act ? S_FO_W : S_ENV;
      S_FO_W:  if (div_done) state_nxt = S_ENV;
      S_ENV:   state_nxt = S_MG;
      S_MG:    state_nxt = S_PE;
      S_PE:    state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      chan_r      <= '0;
      peak_r      <= '0;
      clip_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready && !(state_r == S_FIN && out_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            neg_r <= in_raw[SAMPLE_BITS-1];
            mag_r <= in_raw[SAMPLE_BITS-1] ? (~in_raw + 1'b1) : in_raw;
          end
        end
        S_FI: begin
          if (!fi_act) fi_r <= afgp_pkg::ENV_ONE;
        end
        S_FI_W: begin
          if (div_done) fi_r <= div_quo;
        end
        S_FO: begin
          if (!fo_act) fo_r <= afgp_pkg::ENV_ONE;
        end
        S_FO_W: begin
          if (div_done) begin
            fo_r <= (div_quo > afgp_pkg::ENV_ONE) ? afgp_pkg::ENV_ONE : div_quo;
          end
        end
        S_MG: begin
          env_r <= mul_p[afgp_pkg::ENV_FRAC +: EW];
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sample_res;
            out_peak_r   <= peak_nxt;
            out_clip_r   <= clip_nxt;
            out_end_r    <= take_end;
            pos_r        <= pos_nxt;
            chan_r       <= chan_nxt;
            peak_r       <= take_end ? '0 : peak_nxt;
            clip_r       <= take_end ? 1'b0 : clip_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  afgp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  afgp_mul #(
    .A_W (A_W),
    .B_W (EW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FI_W || state_r == S_FO_W))
    else $error("divider finished outside a ramp wait");

  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENV) |-> (fi_r <= afgp_pkg::ENV_ONE && fo_r <= afgp_pkg::ENV_ONE))
    else $error("ramp above unity");

  a_clip_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clip_r) |-> (out_peak_r > FULL_M))
    else $error("clip flag without peak above full scale");

  a_take_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free && take_end) |=>
      (pos_r == '0 && chan_r == '0 && peak_r == '0 && !clip_r))
    else $error("take state not cleared after last sample");

endmodule
